[hdl/gww_pkg.sv]
// -----------------------------------------------------------------------------
// gww_pkg: shared definitions for the greedy word wrapper
// Character codes, register reset values, the flush sequencer states and the
// completion record passed from the flush engine back to the front end.
// -----------------------------------------------------------------------------
package gww_pkg;

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam logic [7:0] LW_RESET = 8'd40;

	localparam int unsigned COL_W = 9;
	localparam logic [COL_W-1:0] COL_MAX = 9'd511;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_NL,
		SEQ_WORD,
		SEQ_DELIM
	} gww_seq_e;

	// Raised by the flush engine when the last read of a word bank has been issued.
	typedef struct packed {
		logic valid;
		logic bank;
	} gww_done_t;

endpackage

[hdl/gww_in_if.sv]
// -----------------------------------------------------------------------------
// gww_in_if: text input channel
// Valid/ready channel carrying one text byte per item.
// -----------------------------------------------------------------------------
interface gww_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

[hdl/gww_out_if.sv]
// -----------------------------------------------------------------------------
// gww_out_if: wrapped output channel
// Valid/ready channel carrying one output byte and its end-of-run flag per item.
// -----------------------------------------------------------------------------
interface gww_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hdl/gww_cmd_fifo.sv]
// -----------------------------------------------------------------------------
// gww_cmd_fifo: two-entry flush command queue
// Decouples the front end, which classifies text bytes, from the flush engine.
// -----------------------------------------------------------------------------
module gww_cmd_fifo #(
	parameter int unsigned W = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);
	import gww_pkg::*;

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/gww_front.sv]
// -----------------------------------------------------------------------------
// gww_front: byte classifier and line bookkeeping
// Collects word bytes into one of two word banks, decides on a wrap when a
// delimiter arrives and queues a flush command for the flush engine.
// -----------------------------------------------------------------------------
module gww_front #(
	parameter int unsigned WORD_CAP = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             line_width_we,
	input  logic [7:0]       line_width_wdata,
	gww_in_if.sink           text,
	output logic             push,
	output logic [$clog2(WORD_CAP+1)+2:0] push_data,
	input  logic             fifo_full,
	output logic             wr_en,
	output logic [((WORD_CAP > 1) ? $clog2(WORD_CAP) : 1):0] wr_addr,
	output logic [7:0]       wr_data,
	input  gww_pkg::gww_done_t done
);
	import gww_pkg::*;

	localparam int unsigned LEN_W = $clog2(WORD_CAP + 1);
	localparam int unsigned IDX_W = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;

	logic [7:0]       lw_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [LEN_W-1:0] wlen_q;
	logic [COL_W-1:0] col_q;

	logic             accept;
	logic             is_delim;
	logic             is_nl;
	logic             wrap;
	logic [COL_W:0]   span;
	logic [COL_W:0]   col_sum;
	logic [COL_W-1:0] col_d;

	assign text.ready = !busy_q[bank_q] && !fifo_full;
	assign accept     = text.valid && text.ready;
	assign is_nl      = (text.text_byte == CH_NEWLINE);
	assign is_delim   = is_nl || (text.text_byte == CH_SPACE);

	assign span    = {1'b0, col_q} + (COL_W+1)'(wlen_q);
	assign wrap    = span > {2'b00, lw_q};
	assign col_sum = (wrap ? '0 : {1'b0, col_q}) + (COL_W+1)'(wlen_q) + (COL_W+1)'(1);

	always_comb begin
		if (is_nl) begin
			col_d = '0;
		end else if (col_sum > {1'b0, COL_MAX}) begin
			col_d = COL_MAX;
		end else begin
			col_d = col_sum[COL_W-1:0];
		end
	end

	// Bytes beyond the word capacity are dropped and do not count.
	assign wr_en   = accept && !is_delim && (wlen_q < LEN_W'(WORD_CAP));
	assign wr_addr = {bank_q, wlen_q[IDX_W-1:0]};
	assign wr_data = text.text_byte;

	assign push      = accept && is_delim;
	assign push_data = {wrap, is_nl, bank_q, wlen_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q   <= LW_RESET;
			bank_q <= 1'b0;
			busy_q <= 2'b00;
			wlen_q <= '0;
			col_q  <= '0;
		end else begin
			if (line_width_we) begin
				lw_q <= line_width_wdata;
			end
			if (done.valid) begin
				busy_q[done.bank] <= 1'b0;
			end
			if (wr_en) begin
				wlen_q <= wlen_q + LEN_W'(1);
			end
			if (push) begin
				busy_q[bank_q] <= 1'b1;
				bank_q         <= ~bank_q;
				wlen_q         <= '0;
				col_q          <= col_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_write_busy_bank: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !busy_q[bank_q])
		else $error("word byte written into a bank awaiting flush");
	a_done_on_busy_bank: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> busy_q[done.bank])
		else $error("flush completion for a bank that was not queued");
	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LEN_W'(WORD_CAP))
		else $error("word length beyond capacity");
`endif

endmodule

[hdl/gww_back.sv]
// -----------------------------------------------------------------------------
// gww_back: flush engine
// Holds the two word banks, pops flush commands and emits the optional
// newline, the stored word and the delimiter through a two-stage output path.
// -----------------------------------------------------------------------------
module gww_back #(
	parameter int unsigned WORD_CAP = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [((WORD_CAP > 1) ? $clog2(WORD_CAP) : 1):0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic [$clog2(WORD_CAP+1)+2:0] cmd_data,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output gww_pkg::gww_done_t done,
	gww_out_if.source        wrapped
);
	import gww_pkg::*;

	localparam int unsigned LEN_W = $clog2(WORD_CAP + 1);
	localparam int unsigned IDX_W = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
	localparam int unsigned MEM_D = 2 ** (IDX_W + 1);

	logic [7:0] mem [MEM_D];

	gww_seq_e         state_q;
	gww_seq_e         state_d;
	logic [LEN_W-1:0] cmd_len_q;
	logic             cmd_bank_q;
	logic             cmd_nl_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;

	logic             adv;
	logic             req_valid;
	logic             req_mem;
	logic [7:0]       req_byte;
	logic             req_last;

	logic             s1_valid_q;
	logic             s1_mem_q;
	logic [7:0]       s1_byte_q;
	logic             s1_last_q;
	logic [7:0]       rd_q;

	logic             s2_valid_q;
	logic [7:0]       s2_byte_q;
	logic             s2_last_q;

	logic             c_wrap;
	logic             c_nl;
	logic             c_bank;
	logic [LEN_W-1:0] c_len;

	assign {c_wrap, c_nl, c_bank, c_len} = cmd_data;

	// Both stages move together whenever the output register is free or taken.
	assign adv = !s2_valid_q || wrapped.ready;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		cmd_pop    = 1'b0;
		req_valid  = 1'b0;
		req_mem    = 1'b0;
		req_byte   = CH_NEWLINE;
		req_last   = 1'b0;
		done.valid = 1'b0;
		done.bank  = cmd_bank_q;
		case (state_q)
			SEQ_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					idx_d   = '0;
					if (c_wrap) begin
						state_d = SEQ_NL;
					end else if (c_len != '0) begin
						state_d = SEQ_WORD;
					end else begin
						state_d = SEQ_DELIM;
					end
				end
			end
			SEQ_NL: begin
				if (adv) begin
					req_valid = 1'b1;
					state_d   = (cmd_len_q != '0) ? SEQ_WORD : SEQ_DELIM;
				end
			end
			SEQ_WORD: begin
				if (adv) begin
					req_valid = 1'b1;
					req_mem   = 1'b1;
					idx_d     = idx_q + IDX_W'(1);
					if (LEN_W'(idx_q) + LEN_W'(1) == cmd_len_q) begin
						state_d = SEQ_DELIM;
					end
				end
			end
			SEQ_DELIM: begin
				if (adv) begin
					req_valid  = 1'b1;
					req_byte   = cmd_nl_q ? CH_NEWLINE : CH_SPACE;
					req_last   = 1'b1;
					done.valid = 1'b1;
					state_d    = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (cmd_pop) begin
			cmd_len_q  <= c_len;
			cmd_bank_q <= c_bank;
			cmd_nl_q   <= c_nl;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (adv && req_mem) begin
			rd_q <= mem[{cmd_bank_q, idx_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= req_valid;
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_mem_q  <= req_mem;
			s1_byte_q <= req_byte;
			s1_last_q <= req_last;
			s2_byte_q <= s1_mem_q ? rd_q : s1_byte_q;
			s2_last_q <= s1_last_q;
		end
	end

	assign wrapped.valid       = s2_valid_q;
	assign wrapped.out_byte    = s2_byte_q;
	assign wrapped.last_of_run = s2_last_q;

`ifndef NO_ASSERTIONS
	a_read_within_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_WORD |-> LEN_W'(idx_q) < cmd_len_q)
		else $error("word read beyond stored length");
	a_last_is_delim: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && s2_last_q |-> s2_byte_q == CH_SPACE || s2_byte_q == CH_NEWLINE)
		else $error("end of run on a byte that is not a delimiter");
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q != SEQ_IDLE)
		else $error("flush command popped without starting a flush");
`endif

endmodule

[hdl/greedy_word_wrap.sv]
// -----------------------------------------------------------------------------
// greedy_word_wrap: greedy word wrapping of a byte stream
// Words are gathered into one of two banks; each space or newline queues a
// flush that emits an optional wrap newline, the word and the delimiter.
//
//   channel   dir  handshake    payload
//   text      in   valid/ready  text_byte[7:0]
//   wrapped   out  valid/ready  out_byte[7:0], last_of_run
//   config    in   write only   line_width_wdata[7:0] when line_width_we
//
// A delimiter queues a flush of N+1 or N+2 items for a word of N bytes; the
// flush engine emits one item a cycle while the output is not stalled, and
// fetches each command from the queue before it starts that flush.
// The input stalls only while both word banks await their flush.
// Reset is asynchronous and clears all control state; no clearing pass.
// -----------------------------------------------------------------------------
module greedy_word_wrap #(
	parameter int unsigned WORD_CAP = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_width_we,
	input  logic [7:0] line_width_wdata,
	gww_in_if.sink     text,
	gww_out_if.source  wrapped
);
	import gww_pkg::*;

	localparam int unsigned LEN_W = $clog2(WORD_CAP + 1);
	localparam int unsigned IDX_W = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
	localparam int unsigned CMD_W = LEN_W + 3;

	logic             push;
	logic [CMD_W-1:0] push_data;
	logic             pop;
	logic [CMD_W-1:0] pop_data;
	logic             fifo_full;
	logic             fifo_empty;
	logic             wr_en;
	logic [IDX_W:0]   wr_addr;
	logic [7:0]       wr_data;
	gww_done_t        done;

	gww_front #(
		.WORD_CAP (WORD_CAP)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_width_we    (line_width_we),
		.line_width_wdata (line_width_wdata),
		.text             (text),
		.push             (push),
		.push_data        (push_data),
		.fifo_full        (fifo_full),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.done             (done)
	);

	gww_cmd_fifo #(
		.W (CMD_W)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	gww_back #(
		.WORD_CAP (WORD_CAP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.cmd_data  (pop_data),
		.cmd_empty (fifo_empty),
		.cmd_pop   (pop),
		.done      (done),
		.wrapped   (wrapped)
	);

endmodule
